### hw/rtl/gop_xor_delta_frame_encoder_defines.svh
// assertion macros used by the checker file
`ifndef GOP_XOR_DELTA_FRAME_ENCODER_DEFINES_SVH
`define GOP_XOR_DELTA_FRAME_ENCODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GXD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gxd assertion failed");

// next-cycle implication, checked outside reset
`define GXD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gxd assertion failed");

`endif

### hw/rtl/gxd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gxd_pkg
// shared widths, register indexes and the sequencer info struct
// ----------------------------------------------------------------------------
package gxd_pkg;

    localparam int MAX_FRAME_WORDS = 4096;
    localparam int ADDR_W          = $clog2(MAX_FRAME_WORDS);
    localparam int WORD_W          = 64;
    localparam int FW_W            = 13;
    localparam int GOP_W           = 16;
    localparam int CFG_W           = 16;

    localparam logic [FW_W-1:0]  FW_RESET  = FW_W'(MAX_FRAME_WORDS);
    localparam logic [GOP_W-1:0] GOP_RESET = GOP_W'(30);
    localparam logic [FW_W-1:0]  FW_MAX    = FW_W'(MAX_FRAME_WORDS);

    // configuration register indexes
    localparam logic CFG_FRAME_WORDS = 1'b0;
    localparam logic CFG_GOP_LENGTH  = 1'b1;

    // per-word information from the sequencer
    typedef struct packed {
        logic [ADDR_W-1:0] pos;
        logic              key;
        logic              last;
    } seq_info_t;

endpackage

### hw/rtl/gxd_frame_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gxd_frame_ram
// single-clock ram, one read and one write port, read-first, registered read
// ----------------------------------------------------------------------------
module gxd_frame_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 64
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/gxd_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gxd_seq
// configuration registers plus word and group position counters
// ----------------------------------------------------------------------------
module gxd_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [gxd_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        advance,
    output gxd_pkg::seq_info_t          info
);

    logic [gxd_pkg::FW_W-1:0]   frame_words_reg;
    logic [gxd_pkg::GOP_W-1:0]  gop_length_reg;
    logic [gxd_pkg::ADDR_W-1:0] word_pos_reg, word_pos_next;
    logic [gxd_pkg::GOP_W-1:0]  group_pos_reg, group_pos_next;

    logic [gxd_pkg::FW_W-1:0]   eff_fw;
    logic [gxd_pkg::GOP_W-1:0]  eff_gop;
    logic [gxd_pkg::FW_W-1:0]   pos_plus;
    logic [gxd_pkg::GOP_W:0]    group_plus;
    logic                       last;

    always_comb
    begin
        // zero acts as one, oversize clamps to the store depth
        eff_fw = frame_words_reg;
        if (frame_words_reg == '0)
        begin
            eff_fw = gxd_pkg::FW_W'(1);
        end
        else if (frame_words_reg > gxd_pkg::FW_MAX)
        begin
            eff_fw = gxd_pkg::FW_MAX;
        end
        eff_gop = (gop_length_reg == '0) ? gxd_pkg::GOP_W'(1) : gop_length_reg;

        pos_plus   = gxd_pkg::FW_W'(word_pos_reg) + gxd_pkg::FW_W'(1);
        group_plus = {1'b0, group_pos_reg} + (gxd_pkg::GOP_W+1)'(1);
        last       = (pos_plus >= eff_fw);

        word_pos_next  = word_pos_reg;
        group_pos_next = group_pos_reg;
        if (advance)
        begin
            if (last)
            begin
                word_pos_next = '0;
                if (group_plus >= {1'b0, eff_gop})
                begin
                    group_pos_next = '0;
                end
                else
                begin
                    group_pos_next = group_plus[gxd_pkg::GOP_W-1:0];
                end
            end
            else
            begin
                word_pos_next = pos_plus[gxd_pkg::ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_words_reg <= gxd_pkg::FW_RESET;
            gop_length_reg  <= gxd_pkg::GOP_RESET;
            word_pos_reg    <= '0;
            group_pos_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gxd_pkg::CFG_FRAME_WORDS: frame_words_reg <= cfg_wdata[gxd_pkg::FW_W-1:0];
                    gxd_pkg::CFG_GOP_LENGTH:  gop_length_reg  <= cfg_wdata[gxd_pkg::GOP_W-1:0];
                    default: ;
                endcase
            end
            word_pos_reg  <= word_pos_next;
            group_pos_reg <= group_pos_next;
        end
    end

    assign info.pos  = word_pos_reg;
    assign info.key  = (group_pos_reg == '0);
    assign info.last = last;

endmodule

### hw/rtl/gop_xor_delta_frame_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gop_xor_delta_frame_encoder
// xor delta frame coder with periodic keyframes over a 64-bit word stream
// ----------------------------------------------------------------------------
//
// channel | direction | handshake             | payload
// --------+-----------+-----------------------+-------------------------------------
// in      | input     | in_valid / in_ready   | data_word
// out     | output    | out_valid / out_ready | delta_word, is_keyframe, frame_end
// cfg     | input     | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// one word per clock sustained while out_ready stays high, bounded by the single
// read port of the frame store, which is read and written in the same cycle;
// each transaction passes the frame store read stage, then the output register
// reset clears counters and valid flags, presets config; the store is not cleared
// a stalled output holds the result and still lets one more word enter
//
module gop_xor_delta_frame_encoder (
    input  logic                       clk,
    input  logic                       rst_n,
    // input stream
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [63:0]                data_word,
    // output stream
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [63:0]                delta_word,
    output logic                       is_keyframe,
    output logic                       frame_end,
    // configuration writes
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [gxd_pkg::CFG_W-1:0]  cfg_wdata
);

    gxd_pkg::seq_info_t          info;
    logic                        in_fire;
    logic                        s1_adv;
    logic [gxd_pkg::WORD_W-1:0]  prev_word;

    // read stage: the store read data lines up with these registers
    logic                        s1_valid_reg, s1_valid_next;
    logic [gxd_pkg::WORD_W-1:0]  s1_word_reg;
    logic                        s1_key_reg;
    logic                        s1_last_reg;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [gxd_pkg::WORD_W-1:0]  out_word_reg;
    logic                        out_key_reg;
    logic                        out_last_reg;

    // output register frees up when empty or when its transaction completes
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    // position and keyframe tracking, config registers
    gxd_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (in_fire),
        .info      (info)
    );

    // previous frame: read old word and write the new one at the same slot;
    // a word at the same slot in the very next cycle already sees this write
    gxd_frame_ram #(
        .ADDR_W (gxd_pkg::ADDR_W),
        .DATA_W (gxd_pkg::WORD_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (info.pos),
        .rd_data (prev_word),
        .wr_en   (in_fire),
        .wr_addr (info.pos),
        .wr_data (data_word)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_word_reg <= data_word;
            s1_key_reg  <= info.key;
            s1_last_reg <= info.last;
        end
        if (s1_adv)
        begin
            // keyframes pass raw, predicted frames xor against the stored word
            out_word_reg <= s1_key_reg ? s1_word_reg : (s1_word_reg ^ prev_word);
            out_key_reg  <= s1_key_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign delta_word  = out_word_reg;
    assign is_keyframe = out_key_reg;
    assign frame_end   = out_last_reg;

endmodule

### hw/rtl/gxd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gxd_checker
// port-level checks on the frame encoder, bound to the top level
// ----------------------------------------------------------------------------
`include "gop_xor_delta_frame_encoder_defines.svh"

module gxd_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [63:0]                delta_word,
    input  logic                       is_keyframe,
    input  logic                       frame_end
);

    // a stalled result holds
    `GXD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(delta_word) && $stable(is_keyframe) && $stable(frame_end))

    // the keyframe mark only changes across a frame end
    `GXD_ASSERT_NEXT(a_key_in_frame, out_valid && out_ready && !frame_end,
        !out_valid || (is_keyframe == $past(is_keyframe)))

    // the output is expected valid once an accepted word has moved through the read stage into the output register
    `GXD_ASSERT_NEXT(a_latency, in_valid && in_ready, ##1 out_valid)

endmodule

bind gop_xor_delta_frame_encoder gxd_checker u_gxd_checker (.*);
